/* sv/jtus_pkg.sv */
package jtus_pkg;

  localparam int IR_WIDTH = 10;
  localparam int CODE_W = 10;
  localparam int CFG_IDX_W = 2;

  localparam logic [CODE_W-1:0] USER1_CODE_RST = 10'd962;
  localparam logic [CODE_W-1:0] USER2_CODE_RST = 10'd963;

  localparam logic [CFG_IDX_W-1:0] CFG_USER1_CODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USER2_CODE = 2'd1;

  // TAP controller states, IEEE 1149.1 encoding order.
  localparam logic [3:0] ST_TLR      = 4'd0;
  localparam logic [3:0] ST_RTI      = 4'd1;
  localparam logic [3:0] ST_SEL_DR   = 4'd2;
  localparam logic [3:0] ST_CAP_DR   = 4'd3;
  localparam logic [3:0] ST_SHIFT_DR = 4'd4;
  localparam logic [3:0] ST_EXIT1_DR = 4'd5;
  localparam logic [3:0] ST_PAUSE_DR = 4'd6;
  localparam logic [3:0] ST_EXIT2_DR = 4'd7;
  localparam logic [3:0] ST_UPD_DR   = 4'd8;
  localparam logic [3:0] ST_SEL_IR   = 4'd9;
  localparam logic [3:0] ST_CAP_IR   = 4'd10;
  localparam logic [3:0] ST_SHIFT_IR = 4'd11;
  localparam logic [3:0] ST_EXIT1_IR = 4'd12;
  localparam logic [3:0] ST_PAUSE_IR = 4'd13;
  localparam logic [3:0] ST_EXIT2_IR = 4'd14;
  localparam logic [3:0] ST_UPD_IR   = 4'd15;

  typedef struct packed {
    logic trst_n;
    logic tck_high;
    logic tms;
    logic tdi;
    logic user_tdo;
  } in_t;

  typedef struct packed {
    logic tdo;
    logic sel_user1;
    logic sel_user2;
    logic tdi_out;
    logic drck;
    logic dr_capture;
    logic dr_shift;
    logic dr_update;
    logic test_reset;
  } out_t;

  function automatic logic [3:0] tap_next(input logic [3:0] st, input logic tms);
    logic [3:0] nxt;
    nxt = ST_TLR;
    unique case (st)
      ST_TLR:      nxt = tms ? ST_TLR      : ST_RTI;
      ST_RTI:      nxt = tms ? ST_SEL_DR   : ST_RTI;
      ST_SEL_DR:   nxt = tms ? ST_SEL_IR   : ST_CAP_DR;
      ST_CAP_DR:   nxt = tms ? ST_EXIT1_DR : ST_SHIFT_DR;
      ST_SHIFT_DR: nxt = tms ? ST_EXIT1_DR : ST_SHIFT_DR;
      ST_EXIT1_DR: nxt = tms ? ST_UPD_DR   : ST_PAUSE_DR;
      ST_PAUSE_DR: nxt = tms ? ST_EXIT2_DR : ST_PAUSE_DR;
      ST_EXIT2_DR: nxt = tms ? ST_UPD_DR   : ST_SHIFT_DR;
      ST_UPD_DR:   nxt = tms ? ST_SEL_DR   : ST_RTI;
      ST_SEL_IR:   nxt = tms ? ST_TLR      : ST_CAP_IR;
      ST_CAP_IR:   nxt = tms ? ST_EXIT1_IR : ST_SHIFT_IR;
      ST_SHIFT_IR: nxt = tms ? ST_EXIT1_IR : ST_SHIFT_IR;
      ST_EXIT1_IR: nxt = tms ? ST_UPD_IR   : ST_PAUSE_IR;
      ST_PAUSE_IR: nxt = tms ? ST_EXIT2_IR : ST_PAUSE_IR;
      ST_EXIT2_IR: nxt = tms ? ST_UPD_IR   : ST_SHIFT_IR;
      ST_UPD_IR:   nxt = tms ? ST_SEL_DR   : ST_RTI;
      default:     nxt = ST_TLR;
    endcase
    return nxt;
  endfunction

  // A code is fitted to the instruction width: zero-extended or truncated.
  function automatic logic code_match(input logic [IR_WIDTH-1:0] ir,
                                      input logic [CODE_W-1:0] code);
    logic [IR_WIDTH-1:0] fitted;
    fitted = IR_WIDTH'(code);
    return ir == fitted;
  endfunction

endpackage

/* sv/jtus_tap.sv */
module jtus_tap (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step,
  input  jtus_pkg::in_t                   item,
  input  logic [jtus_pkg::CODE_W-1:0]     user1_code,
  input  logic [jtus_pkg::CODE_W-1:0]     user2_code,
  output jtus_pkg::out_t                  result
);

  logic [3:0]                      state_r;
  logic [3:0]                      state_nxt;
  logic [jtus_pkg::IR_WIDTH-1:0]   ir_r;
  logic [jtus_pkg::IR_WIDTH-1:0]   ir_nxt;
  logic                            sel1_r;
  logic                            sel1_nxt;
  logic                            sel2_r;
  logic                            sel2_nxt;

  // The result reflects the state before this item's clock edge.
  always_comb begin
    result.tdo        = item.user_tdo;
    result.sel_user1  = sel1_r;
    result.sel_user2  = sel2_r;
    result.tdi_out    = item.tdi;
    result.drck       = (sel1_r | sel2_r) ? item.tck_high : 1'b1;
    result.dr_capture = (state_r == jtus_pkg::ST_CAP_DR);
    result.dr_shift   = (state_r == jtus_pkg::ST_SHIFT_DR);
    result.dr_update  = (state_r == jtus_pkg::ST_UPD_DR);
    result.test_reset = (state_r == jtus_pkg::ST_TLR);
  end

  always_comb begin
    state_nxt = state_r;
    ir_nxt    = ir_r;
    sel1_nxt  = sel1_r;
    sel2_nxt  = sel2_r;
    if (item.tck_high) begin
      if (!item.trst_n) begin
        state_nxt = jtus_pkg::ST_TLR;
        ir_nxt    = '0;
        sel1_nxt  = 1'b0;
        sel2_nxt  = 1'b0;
      end else begin
        state_nxt = jtus_pkg::tap_next(state_r, item.tms);
        if (state_r == jtus_pkg::ST_UPD_IR) begin
          sel1_nxt = jtus_pkg::code_match(ir_r, user1_code);
          sel2_nxt = jtus_pkg::code_match(ir_r, user2_code);
        end else if (state_r == jtus_pkg::ST_CAP_IR) begin
          sel1_nxt = 1'b0;
          sel2_nxt = 1'b0;
        end
        if (state_r == jtus_pkg::ST_CAP_IR) begin
          ir_nxt = '0;
        end else if (state_r == jtus_pkg::ST_SHIFT_IR) begin
          ir_nxt = {item.tdi, ir_r[jtus_pkg::IR_WIDTH-1:1]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= jtus_pkg::ST_TLR;
      ir_r    <= '0;
      sel1_r  <= 1'b0;
      sel2_r  <= 1'b0;
    end else if (step) begin
      state_r <= state_nxt;
      ir_r    <= ir_nxt;
      sel1_r  <= sel1_nxt;
      sel2_r  <= sel2_nxt;
    end
  end

endmodule

/* sv/jtag_tap_user_scan.sv */
// TAP controller with two user scan-chain selects, driven one test clock
// phase at a time.
// Input channel (in_valid, in_stall, in_data): each transaction is one half
// phase of TCK with TRST_n, TMS, TDI and the user chain's TDO. A high phase
// advances the TAP state machine, the instruction register and the selects.
// Output channel (out_valid, out_stall, out_data): one transaction per input
// transaction, in order, showing the TAP flags and selects as they stood
// before that phase's edge, plus DRCK and the TDI/TDO pass-through.
// The output is registered; one transaction per cycle is sustained while
// out_stall is low, since the TAP update is a few gates between the state
// registers and the output register.
// A two-entry output stage (register plus skid) keeps input accepted while
// a result waits; in_stall rises only once both entries are full.
// Configuration: cfg_index 0 writes the user one code, 1 the user two code;
// other indexes are ignored. cfg_ready is always high.
// Reset puts the TAP in Test-Logic-Reset, clears the instruction register
// and selects, restores the default codes and empties the output stage.
module jtag_tap_user_scan (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  jtus_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output jtus_pkg::out_t                    out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [jtus_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [jtus_pkg::CODE_W-1:0]       cfg_data
);

  logic [jtus_pkg::CODE_W-1:0] user1_code_r;
  logic [jtus_pkg::CODE_W-1:0] user2_code_r;
  logic                        in_fire;
  logic                        out_free;
  jtus_pkg::out_t              result;
  jtus_pkg::out_t              out_data_r;
  jtus_pkg::out_t              skid_data_r;
  logic                        out_valid_r;
  logic                        skid_valid_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      user1_code_r <= jtus_pkg::USER1_CODE_RST;
      user2_code_r <= jtus_pkg::USER2_CODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == jtus_pkg::CFG_USER1_CODE) begin
        user1_code_r <= cfg_data;
      end
      if (cfg_index == jtus_pkg::CFG_USER2_CODE) begin
        user2_code_r <= cfg_data;
      end
    end
  end

  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid && !skid_valid_r;
  assign out_free = !out_valid_r || !out_stall;

  jtus_tap u_tap (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (in_fire),
    .item       (in_data),
    .user1_code (user1_code_r),
    .user2_code (user2_code_r),
    .result     (result)
  );

  // The skid entry is older than any new transaction, so it drains first;
  // in_stall is high while it is occupied.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_r  <= skid_valid_r || in_fire;
        skid_valid_r <= 1'b0;
      end else if (in_fire) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : result;
    end
    if (!out_free && in_fire) begin
      skid_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sv/jtus_checker.sv */
module jtus_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input jtus_pkg::out_t  out_data
);

  // The output stage holds two entries, so a single stalled result never
  // blocks the input side.
  a_no_early_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(out_valid) |-> !in_stall)
    else $error("input stalled while the output stage was empty");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_data.dr_capture, out_data.dr_shift,
                            out_data.dr_update, out_data.test_reset}))
    else $error("more than one TAP state flag set");

  a_drck_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.sel_user1 && !out_data.sel_user2 |-> out_data.drck)
    else $error("drck toggled with no user chain selected");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

endmodule

bind jtag_tap_user_scan jtus_checker u_jtus_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
